// ===== hdl/bsa_pkg.sv =====
// Shared types and constants of the buffer slot handle allocator.
// Holds the beat field widths, the action and status codes and the FSM type.
// No dependencies.
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int ACTION_W     = 2;
  localparam int REQ_SIZE_W   = 20;
  localparam int HANDLE_IN_W  = 32;
  localparam int STATUS_W     = 3;
  localparam int HANDLE_OUT_W = 32;
  localparam int SIZE_OUT_W   = 20;
  localparam int SLOT_OUT_W   = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_VIEW    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_CLOSED   = 3'd1,
    ST_BADARG   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACQ  = 4'b0010,
    S_LOOK = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

endpackage

// ===== hdl/bsa_req_if.sv =====
// Request channel of the buffer slot handle allocator.
// Carries valid, ready and the request fields; uses bsa_pkg for widths.
`timescale 1ns / 1ps

interface bsa_req_if;
  import bsa_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ACTION_W-1:0]    action;
  logic [REQ_SIZE_W-1:0]  request_size;
  logic [HANDLE_IN_W-1:0] handle_in;

  modport source (output valid, output action, output request_size, output handle_in,
                  input ready);
  modport sink   (input valid, input action, input request_size, input handle_in,
                  output ready);
endinterface

// ===== hdl/bsa_rsp_if.sv =====
// Response channel of the buffer slot handle allocator.
// Carries valid, ready and the result fields; uses bsa_pkg for widths.
`timescale 1ns / 1ps

interface bsa_rsp_if;
  import bsa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [HANDLE_OUT_W-1:0] handle_out;
  logic [SIZE_OUT_W-1:0]   size_out;
  logic [SLOT_OUT_W-1:0]   slot_out;

  modport source (output valid, output status, output handle_out, output size_out,
                  output slot_out, input ready);
  modport sink   (input valid, input status, input handle_out, input size_out,
                  input slot_out, output ready);
endinterface

// ===== hdl/bsa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bsa_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/buffer_slot_handle_allocator_unit.sv =====
// Buffer slot handle allocator: top level with the slot sequencer.
// Depends on bsa_pkg, bsa_req_if, bsa_rsp_if and bsa_ram.
//
//   channel  direction  handshake       fields
//   req_i    in         valid / ready   action, request_size, handle_in
//   rsp_o    out        valid / ready   status, handle_out, size_out, slot_out
//   cfg      in         cfg_we_i        cfg_wdata_i (store_closed)
//
// One request is in flight at a time. A refused request goes from S_IDLE straight to S_RESP
// and the response register. Acquire walks the busy bits one slot a cycle. View and
// release walk the handle/size RAM one slot a cycle with the compare in the cycle after
// the read. Reset frees every slot at once.
// The response register lets a new request start while the last beat waits on rsp_o.
`timescale 1ns / 1ps

module buffer_slot_handle_allocator_unit #(
  parameter int SLOT_COUNT  = 16,
  parameter int HANDLE_BITS = 32,
  parameter int SIZE_BITS   = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  bsa_req_if.sink   req_i,
  bsa_rsp_if.source rsp_o
);
  import bsa_pkg::*;

  localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ENTRY_W = HANDLE_BITS + SIZE_BITS;
  localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [HANDLE_BITS-1:0] HND_ONE  = HANDLE_BITS'(1);

  state_e                  state_q, state_d;
  logic                    closed_q, closed_d;
  logic [SLOT_COUNT-1:0]   busy_q, busy_d;
  logic [HANDLE_BITS-1:0]  nh_q, nh_d, nh_inc;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    iss_done_q, iss_done_d;
  logic                    pend_q, pend_d;
  logic [IDX_W-1:0]        pend_idx_q, pend_idx_d;
  logic                    pend_busy_q, pend_busy_d;
  logic                    out_valid_q, out_valid_d;

  action_e                 act_q, act_d;
  logic [SIZE_BITS-1:0]    size_q, size_d;
  logic [HANDLE_BITS-1:0]  hnd_q, hnd_d;
  status_e                 res_status_q, res_status_d;
  logic [HANDLE_OUT_W-1:0] res_handle_q, res_handle_d;
  logic [SIZE_OUT_W-1:0]   res_size_q, res_size_d;
  logic [SLOT_OUT_W-1:0]   res_slot_q, res_slot_d;
  status_e                 out_status_q, out_status_d;
  logic [HANDLE_OUT_W-1:0] out_handle_q, out_handle_d;
  logic [SIZE_OUT_W-1:0]   out_size_q, out_size_d;
  logic [SLOT_OUT_W-1:0]   out_slot_q, out_slot_d;

  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
  logic [HANDLE_BITS-1:0]  rd_handle;
  logic [SIZE_BITS-1:0]    rd_size;
  logic [SIZE_BITS-1:0]    in_size;
  logic [HANDLE_BITS-1:0]  in_hnd;
  logic                    accept, hit;

  bsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_handle = ram_rdata[ENTRY_W-1:SIZE_BITS];
  assign rd_size   = ram_rdata[SIZE_BITS-1:0];
  assign in_size   = SIZE_BITS'(req_i.request_size);
  assign in_hnd    = HANDLE_BITS'(req_i.handle_in);
  assign nh_inc    = nh_q + HND_ONE;

  assign req_i.ready      = (state_q == S_IDLE);
  assign accept           = req_i.valid && req_i.ready;
  assign hit              = pend_q && pend_busy_q && (rd_handle == hnd_q);

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.handle_out = out_handle_q;
  assign rsp_o.size_out   = out_size_q;
  assign rsp_o.slot_out   = out_slot_q;

  always_comb begin
    state_d      = state_q;
    closed_d     = cfg_we_i ? cfg_wdata_i : closed_q;
    busy_d       = busy_q;
    nh_d         = nh_q;
    idx_d        = idx_q;
    iss_done_d   = iss_done_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    pend_busy_d  = pend_busy_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    act_d        = act_q;
    size_d       = size_q;
    hnd_d        = hnd_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_size_d   = res_size_q;
    res_slot_d   = res_slot_q;
    out_status_d = out_status_q;
    out_handle_d = out_handle_q;
    out_size_d   = out_size_q;
    out_slot_d   = out_slot_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = {nh_q, size_q};
    ram_re       = 1'b0;
    ram_raddr    = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d        = action_e'(req_i.action);
          size_d       = in_size;
          hnd_d        = in_hnd;
          res_status_d = ST_OK;
          res_handle_d = '0;
          res_size_d   = '0;
          res_slot_d   = '0;
          idx_d        = '0;
          iss_done_d   = 1'b0;
          state_d      = S_RESP;
          unique case (action_e'(req_i.action))
            ACT_ACQUIRE: begin
              if (closed_q) begin
                res_status_d = ST_CLOSED;
              end else if (in_size == '0) begin
                res_status_d = ST_BADARG;
              end else begin
                state_d = S_ACQ;
              end
            end
            ACT_VIEW: begin
              if (in_hnd == '0) begin
                res_status_d = ST_BADARG;
              end else if (closed_q) begin
                res_status_d = ST_CLOSED;
              end else begin
                state_d = S_LOOK;
              end
            end
            ACT_RELEASE: begin
              if (in_hnd == '0) begin
                res_status_d = ST_NOTFOUND;
              end else begin
                state_d = S_LOOK;
              end
            end
            default: begin
              res_status_d = ST_BADARG;
            end
          endcase
        end
      end
      S_ACQ: begin
        if (!busy_q[idx_q]) begin
          ram_we            = 1'b1;
          busy_d[idx_q]     = 1'b1;
          nh_d              = (nh_inc == '0) ? HND_ONE : nh_inc;
          res_handle_d      = HANDLE_OUT_W'(nh_q);
          res_slot_d        = SLOT_OUT_W'(idx_q);
          state_d           = S_RESP;
        end else if (idx_q == LAST_IDX) begin
          res_status_d = ST_FULL;
          state_d      = S_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_LOOK: begin
        // Read of slot idx_q is issued while slot pend_idx_q is compared.
        if (!iss_done_q) begin
          ram_re      = 1'b1;
          pend_d      = 1'b1;
          pend_idx_d  = idx_q;
          pend_busy_d = busy_q[idx_q];
          if (idx_q == LAST_IDX) begin
            iss_done_d = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (hit) begin
          res_slot_d = SLOT_OUT_W'(pend_idx_q);
          if (act_q == ACT_RELEASE) begin
            busy_d[pend_idx_q] = 1'b0;
          end else begin
            res_size_d = SIZE_OUT_W'(rd_size);
          end
          state_d = S_RESP;
        end else if (pend_q && (pend_idx_q == LAST_IDX)) begin
          res_status_d = ST_NOTFOUND;
          state_d      = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_handle_d = res_handle_q;
          out_size_d   = res_size_q;
          out_slot_d   = res_slot_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      closed_q    <= 1'b0;
      busy_q      <= '0;
      nh_q        <= HND_ONE;
      idx_q       <= '0;
      iss_done_q  <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      closed_q    <= closed_d;
      busy_q      <= busy_d;
      nh_q        <= nh_d;
      idx_q       <= idx_d;
      iss_done_q  <= iss_done_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    pend_busy_q  <= pend_busy_d;
    act_q        <= act_d;
    size_q       <= size_d;
    hnd_q        <= hnd_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    res_size_q   <= res_size_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_handle_q <= out_handle_d;
    out_size_q   <= out_size_d;
    out_slot_q   <= out_slot_d;
  end

endmodule

// ===== hdl/bsa_checker.sv =====
// Port-level checks on the response channel of the allocator, and the bind
// that attaches them to buffer_slot_handle_allocator_unit. Uses bsa_pkg.
`timescale 1ns / 1ps

module bsa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic [bsa_pkg::STATUS_W-1:0]      rsp_status_i,
  input logic [bsa_pkg::HANDLE_OUT_W-1:0]  rsp_handle_i,
  input logic [bsa_pkg::SIZE_OUT_W-1:0]    rsp_size_i,
  input logic [bsa_pkg::SLOT_OUT_W-1:0]    rsp_slot_i
);
  import bsa_pkg::*;

  // A stalled response beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_handle_i) && $stable(rsp_size_i) && $stable(rsp_slot_i))
    else $error("stalled response beat changed");

  // Every refusal or miss reports all-zero result fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_OK) |->
      (rsp_handle_i == '0) && (rsp_size_i == '0) && (rsp_slot_i == '0))
    else $error("failed response carries nonzero fields");

  // Only acquire returns a handle and only view returns a size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_handle_i == '0) || (rsp_size_i == '0))
    else $error("response carries both a handle and a size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == ST_OK) || (rsp_status_i == ST_CLOSED)
      || (rsp_status_i == ST_BADARG) || (rsp_status_i == ST_FULL)
      || (rsp_status_i == ST_NOTFOUND))
    else $error("response status code out of range");

endmodule

bind buffer_slot_handle_allocator_unit bsa_checker u_bsa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_handle_i (rsp_o.handle_out),
  .rsp_size_i   (rsp_o.size_out),
  .rsp_slot_i   (rsp_o.slot_out)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for buffer_slot_handle_allocator_unit.
// Tracks the slot pool in a scoreboard class and drives both channels with random idling.
// Depends on bsa_pkg, bsa_req_if, bsa_rsp_if and the allocator RTL.
`timescale 1ns / 1ps

module testbench;
  import bsa_pkg::*;

  localparam int SLOTS      = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 100;
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0]    action;
    logic [REQ_SIZE_W-1:0]  size;
    logic [HANDLE_IN_W-1:0] handle;
  } pool_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [HANDLE_OUT_W-1:0] handle;
    logic [SIZE_OUT_W-1:0]   size;
    logic [SLOT_OUT_W-1:0]   slot;
  } pool_reply_t;

  class slot_pool_tracker;
    bit                      store_closed;
    bit                      busy [SLOTS];
    logic [HANDLE_IN_W-1:0]  handle_of [SLOTS];
    logic [REQ_SIZE_W-1:0]   size_of [SLOTS];
    logic [HANDLE_OUT_W-1:0] next_handle;
    logic [HANDLE_IN_W-1:0]  last_freed;
    pool_reply_t             owed_replies [$];
    int unsigned             errors;

    function new();
      store_closed = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        busy[i]      = 1'b0;
        handle_of[i] = '0;
        size_of[i]   = '0;
      end
      next_handle = 1;
      last_freed  = '0;
      errors      = 0;
    endfunction

    // Lowest busy slot that holds the handle, or -1.
    function int holder_of(logic [HANDLE_IN_W-1:0] h);
      for (int i = 0; i < SLOTS; i++) begin
        if (busy[i] && handle_of[i] == h) return i;
      end
      return -1;
    endfunction

    function pool_reply_t pool_outcome(pool_request_t r);
      pool_reply_t y;
      int idx;
      y = '0;
      y.status = ST_OK;
      idx = -1;
      case (r.action)
        ACT_ACQUIRE: begin
          if (store_closed) begin
            y.status = ST_CLOSED;
          end else if (r.size == 0) begin
            y.status = ST_BADARG;
          end else begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
              if (!busy[i]) idx = i;
            end
            if (idx < 0) begin
              y.status = ST_FULL;
            end else begin
              busy[idx]      = 1'b1;
              size_of[idx]   = r.size;
              handle_of[idx] = next_handle;
              y.handle       = next_handle;
              y.slot         = SLOT_OUT_W'(idx);
              next_handle    = next_handle + 1;
              // The counter never hands out zero, even after it wraps.
              if (next_handle == 0) next_handle = 1;
            end
          end
        end
        ACT_VIEW: begin
          if (r.handle == 0) begin
            y.status = ST_BADARG;
          end else if (store_closed) begin
            y.status = ST_CLOSED;
          end else begin
            idx = holder_of(r.handle);
            if (idx < 0) begin
              y.status = ST_NOTFOUND;
            end else begin
              y.size = size_of[idx];
              y.slot = SLOT_OUT_W'(idx);
            end
          end
        end
        ACT_RELEASE: begin
          // A release ignores the closed flag.
          idx = (r.handle == 0) ? -1 : holder_of(r.handle);
          if (idx < 0) begin
            y.status = ST_NOTFOUND;
          end else begin
            busy[idx]      = 1'b0;
            handle_of[idx] = '0;
            size_of[idx]   = '0;
            y.slot         = SLOT_OUT_W'(idx);
            last_freed     = r.handle;
          end
        end
        default: begin
          y.status = ST_BADARG;
        end
      endcase
      return y;
    endfunction

    function void note_request(pool_request_t r);
      owed_replies.push_back(pool_outcome(r));
    endfunction

    function void check_reply(pool_reply_t got);
      pool_reply_t want;
      if (owed_replies.size() == 0) begin
        $error("reply beat with no request pending: status %0d handle %0d slot %0d",
               got.status, got.handle, got.slot);
        errors++;
        return;
      end
      want = owed_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.handle !== want.handle) begin
        $error("handle_out: expected %0d, actual %0d", want.handle, got.handle);
        errors++;
      end
      if (got.size !== want.size) begin
        $error("size_out: expected %0d, actual %0d", want.size, got.size);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $error("slot_out: expected %0d, actual %0d", want.slot, got.slot);
        errors++;
      end
    endfunction

    // Mostly a handle that some busy slot holds, otherwise one that misses.
    function logic [HANDLE_IN_W-1:0] pick_handle();
      int live [$];
      for (int i = 0; i < SLOTS; i++) begin
        if (busy[i]) live.push_back(i);
      end
      if (live.size() != 0 && $urandom_range(0, 9) < 8) begin
        return handle_of[live[$urandom_range(0, live.size() - 1)]];
      end
      case ($urandom_range(0, 4))
        0: return '0;
        1: return last_freed;
        2: return next_handle;
        3: return '1;
        default: return $urandom();
      endcase
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  bsa_req_if req ();
  bsa_rsp_if rsp ();

  buffer_slot_handle_allocator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  slot_pool_tracker tracker = new();

  bit calm;
  int unsigned req_gap_odds;
  int unsigned rsp_stall_odds;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Response side: ready drops in random bursts unless the run has gone calm.
  initial begin
    int unsigned hold;
    hold = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && hold == 0 && $urandom_range(0, 99) < rsp_stall_odds) begin
        hold = $urandom_range(1, 17);
      end
      if (calm) hold = 0;
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        hold--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    pool_reply_t got;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got.status = rsp.status;
      got.handle = rsp.handle_out;
      got.size   = rsp.size_out;
      got.slot   = rsp.slot_out;
      tracker.check_reply(got);
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [REQ_SIZE_W-1:0] sz,
                              input logic [HANDLE_IN_W-1:0] h);
    pool_request_t r;
    r.action = act;
    r.size   = sz;
    r.handle = h;
    if (!calm && $urandom_range(0, 99) < req_gap_odds) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.action       <= act;
    req.request_size <= sz;
    req.handle_in    <= h;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    tracker.note_request(r);
  endtask

  task automatic send_random(input int acquire_odds);
    int roll;
    logic [ACTION_W-1:0]    act;
    logic [REQ_SIZE_W-1:0]  sz;
    logic [HANDLE_IN_W-1:0] h;
    roll = $urandom_range(0, 99);
    sz   = REQ_SIZE_W'($urandom_range(1, 20'hFFFFF));
    h    = $urandom();
    case ($urandom_range(0, 19))
      0:       sz = '0;
      1:       sz = '1;
      2, 3:    sz = REQ_SIZE_W'($urandom_range(1, 64));
      default: ;
    endcase
    if (roll < acquire_odds) begin
      act = ACT_ACQUIRE;
    end else if (roll < acquire_odds + 22) begin
      act = ACT_VIEW;
      h   = tracker.pick_handle();
    end else if (roll < 97) begin
      act = ACT_RELEASE;
      h   = tracker.pick_handle();
    end else begin
      act = ACT_UNKNOWN;
    end
    send_request(act, sz, h);
  endtask

  // Leaves the request channel idle until every reply has come back.
  task automatic drain();
    req.valid <= 1'b0;
    while (tracker.owed_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_closed(input bit closed);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= closed;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.store_closed = closed;
  endtask

  initial begin
    calm           = 1'b0;
    req_gap_odds   = 20;
    rsp_stall_odds = 10;
    quiet_cycles   = 0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= 1'b0;
    req.valid        <= 1'b0;
    req.action       <= ACT_ACQUIRE;
    req.request_size <= '0;
    req.handle_in    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, error orderings, misses and the unknown action.
    write_closed(1'b0);
    send_request(ACT_ACQUIRE, '0, '0);
    send_request(ACT_ACQUIRE, 20'd1, '0);
    send_request(ACT_ACQUIRE, '1, '1);
    send_request(ACT_VIEW, '1, 32'd1);
    send_request(ACT_VIEW, '0, 32'd2);
    send_request(ACT_VIEW, '0, '0);
    send_request(ACT_VIEW, '0, '1);
    send_request(ACT_RELEASE, '0, '0);
    send_request(ACT_RELEASE, '1, 32'h8000_0000);
    send_request(ACT_RELEASE, '0, 32'd1);
    send_request(ACT_VIEW, '0, 32'd1);
    send_request(ACT_UNKNOWN, '1, '1);
    send_request(ACT_ACQUIRE, 20'h80000, '0);
    drain();
    write_closed(1'b1);
    send_request(ACT_ACQUIRE, 20'd5, '0);
    send_request(ACT_ACQUIRE, '0, '0);
    send_request(ACT_VIEW, '0, '0);
    send_request(ACT_VIEW, '0, 32'd2);
    send_request(ACT_RELEASE, '0, 32'd2);
    send_request(ACT_RELEASE, '0, 32'd2);
    drain();

    // Random phases alternate between filling the pool, draining it and a closed store.
    for (int p = 0; p < PHASES; p++) begin
      write_closed(p % 4 == 2);
      calm           = (p >= PHASES - 2);
      req_gap_odds   = (p % 5 == 3) ? 0 : 20;
      rsp_stall_odds = (p % 5 == 4) ? 0 : 10;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case (p % 3)
          0:       send_random(60);
          1:       send_random(45);
          default: send_random(28);
        endcase
      end
      drain();
    end

    repeat (30) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.owed_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bsa_pkg.sv
hdl/bsa_req_if.sv
hdl/bsa_rsp_if.sv
hdl/bsa_ram.sv
hdl/buffer_slot_handle_allocator_unit.sv
hdl/bsa_checker.sv
sim/testbench.sv
